// ----- sv/trie_pkg.sv -----
// trie_pkg: shared types and codes for the trie insert/lookup engine.
// No dependencies; imported by trie_insert_lookup_engine_unit.
`timescale 1ns / 1ps
`default_nettype none

package trie_pkg;

   // Fixed field widths of the request and response beats
   localparam int CMD_W    = 2;
   localparam int SYM_W    = 4;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // Command codes (code 3 is unused and acts as a lookup)
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TOUCH  = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_CHECK  = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

endpackage : trie_pkg

`default_nettype wire

// ----- sv/trie_insert_lookup_engine_unit.sv -----
// Sequencing: a symbol beat is accepted in ST_IDLE and its child slot checked in ST_CHECK;
// a word-ending beat then passes ST_FINISH and ST_RESP, which waits for a free response
// register. An empty-word beat, or one whose word already failed or whose symbol is out of
// range, skips ST_CHECK. A new beat is taken only back in ST_IDLE, after the registered
// child-table read has given the next cursor. Reset: synchronous; a clearing pass
// then zeroes the table, one entry a cycle, with req_ready low; csr writes still taken.
`timescale 1ns / 1ps
`default_nettype none

module trie_insert_lookup_engine_unit
   import trie_pkg::*;
#(
   parameter int ALPHABET   = 16,
   parameter int NODE_COUNT = 1024
) (
   input  wire                        clock,
   input  wire                        reset,
   // configuration write channel
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire signed [VALUE_W-1:0]   csr_default_value,
   // request channel
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire        [CMD_W-1:0]     req_command,
   input  wire        [SYM_W-1:0]     req_symbol,
   input  wire                        req_empty_word,
   input  wire                        req_last_symbol,
   input  wire signed [VALUE_W-1:0]   req_store_value,
   // response channel
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic signed [VALUE_W-1:0]  rsp_value,
   output logic       [STATUS_W-1:0]  rsp_status
);

   localparam int NODE_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int TABLE_DEPTH = NODE_COUNT * ALPHABET;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int ALPHA_CMP_W = 9;

   localparam logic [NODE_W:0]      POOL_END  = (NODE_W + 1)'(NODE_COUNT);
   localparam logic [TABLE_AW-1:0]  CLEAR_END = TABLE_AW'(TABLE_DEPTH - 1);

   // memories
   logic [NODE_W-1:0]        child_table_mem [TABLE_DEPTH];
   logic [VALUE_W-1:0]       node_value_mem  [NODE_COUNT];

   // control state
   state_type                state_ff, state_in;
   logic [TABLE_AW-1:0]      clr_addr_ff, clr_addr_in;
   logic [NODE_W-1:0]        cursor_ff, cursor_in;
   logic [NODE_W:0]          next_free_ff, next_free_in;
   logic                     word_failed_ff, word_failed_in;
   logic                     fail_full_ff, fail_full_in;
   logic signed [VALUE_W-1:0] default_ff, default_in;
   logic signed [VALUE_W-1:0] root_value_ff, root_value_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [CMD_W-1:0]         cmd_ff, cmd_in;
   logic                     last_ff, last_in;
   logic signed [VALUE_W-1:0] sval_ff, sval_in;
   logic [TABLE_AW-1:0]      addr_ff, addr_in;
   logic [NODE_W-1:0]        child_rd_ff;
   logic [VALUE_W-1:0]       value_rd_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;

   // memory port controls
   logic                     ct_we;
   logic [TABLE_AW-1:0]      ct_waddr;
   logic [NODE_W-1:0]        ct_wdata;
   logic [TABLE_AW-1:0]      ct_raddr;
   logic                     nv_we;
   logic [NODE_W-1:0]        nv_waddr;
   logic [VALUE_W-1:0]       nv_wdata;

   logic                     sym_bad;
   logic                     cmd_alloc;
   logic                     pool_full;
   logic                     rsp_free;
   logic                     accept;

   // slot address of the incoming symbol under the current cursor
   assign ct_raddr  = TABLE_AW'(32'(cursor_ff) * ALPHABET + 32'(req_symbol));
   assign sym_bad   = (ALPHA_CMP_W'(req_symbol) >= ALPHA_CMP_W'(ALPHABET));
   assign cmd_alloc = (cmd_ff == CMD_INSERT) || (cmd_ff == CMD_TOUCH);
   assign pool_full = (next_free_ff == POOL_END);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign req_ready  = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      cursor_in      = cursor_ff;
      next_free_in   = next_free_ff;
      word_failed_in = word_failed_ff;
      fail_full_in   = fail_full_ff;
      default_in     = default_ff;
      root_value_in  = root_value_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      cmd_in         = cmd_ff;
      last_in        = last_ff;
      sval_in        = sval_ff;
      addr_in        = addr_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      ct_we          = 1'b0;
      ct_waddr       = addr_ff;
      ct_wdata       = next_free_ff[NODE_W-1:0];
      nv_we          = 1'b0;
      nv_waddr       = next_free_ff[NODE_W-1:0];
      nv_wdata       = default_ff;

      // config beat: default value, also the root's value
      if (csr_valid && csr_ready) begin
         default_in    = csr_default_value;
         root_value_in = csr_default_value;
      end

      case (state_ff)
         ST_CLEAR: begin
            ct_we       = 1'b1;
            ct_waddr    = clr_addr_ff;
            ct_wdata    = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CLEAR_END) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in  = req_command;
               last_in = req_last_symbol;
               sval_in = req_store_value;
               addr_in = ct_raddr;
               if (req_empty_word) begin
                  state_in = ST_FINISH;
               end else if (word_failed_ff || sym_bad) begin
                  // skip the walk; an out-of-range symbol is a miss
                  if (!word_failed_ff) begin
                     word_failed_in = 1'b1;
                     fail_full_in   = 1'b0;
                  end
                  state_in = req_last_symbol ? ST_FINISH : ST_IDLE;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (child_rd_ff != '0) begin
               cursor_in = child_rd_ff;
            end else if (!cmd_alloc) begin
               word_failed_in = 1'b1;
               fail_full_in   = 1'b0;
            end else if (pool_full) begin
               word_failed_in = 1'b1;
               fail_full_in   = 1'b1;
            end else begin
               // allocate the next free node as this slot's child
               ct_we        = 1'b1;
               nv_we        = 1'b1;
               cursor_in    = next_free_ff[NODE_W-1:0];
               next_free_in = next_free_ff + 1'b1;
            end
            state_in = last_ff ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            // insert stores its value at the end node
            if (!word_failed_ff && (cmd_ff == CMD_INSERT)) begin
               if (cursor_ff == '0) begin
                  root_value_in = sval_ff;
               end else begin
                  nv_we    = 1'b1;
                  nv_waddr = cursor_ff;
                  nv_wdata = sval_ff;
               end
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (word_failed_ff) begin
                  rsp_value_in  = '0;
                  rsp_status_in = fail_full_ff ? STATUS_FULL : STATUS_MISS;
               end else begin
                  rsp_status_in = STATUS_OK;
                  if (cmd_ff == CMD_INSERT) begin
                     rsp_value_in = sval_ff;
                  end else if (cursor_ff == '0) begin
                     rsp_value_in = root_value_ff;
                  end else begin
                     rsp_value_in = value_rd_ff;
                  end
               end
               // word done: back to the root
               cursor_in      = '0;
               word_failed_in = 1'b0;
               fail_full_in   = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         cursor_ff      <= '0;
         next_free_ff   <= (NODE_W + 1)'(1);
         word_failed_ff <= 1'b0;
         fail_full_ff   <= 1'b0;
         default_ff     <= '0;
         root_value_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         cursor_ff      <= cursor_in;
         next_free_ff   <= next_free_in;
         word_failed_ff <= word_failed_in;
         fail_full_ff   <= fail_full_in;
         default_ff     <= default_in;
         root_value_ff  <= root_value_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      last_ff       <= last_in;
      sval_ff       <= sval_in;
      addr_ff       <= addr_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // child table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ct_we) begin
         child_table_mem[ct_waddr] <= ct_wdata;
      end
      child_rd_ff <= child_table_mem[ct_raddr];
   end

   // node values: one write port, registered read at the cursor
   always_ff @(posedge clock) begin
      if (nv_we) begin
         node_value_mem[nv_waddr] <= nv_wdata;
      end
      value_rd_ff <= node_value_mem[cursor_ff];
   end

   // checks
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= POOL_END)
      else $error("free-node pointer past pool end");

   a_cursor_alloc: assert property (@(posedge clock) disable iff (reset)
      (NODE_W + 1)'(cursor_ff) < next_free_ff)
      else $error("cursor on an unallocated node");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_FULL)) |-> pool_full)
      else $error("pool-full status while nodes remain");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("response raised outside the response step");

   a_word_reset: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && rsp_free) |=> (cursor_ff == '0 && !word_failed_ff))
      else $error("word state not returned to root after response");

endmodule : trie_insert_lookup_engine_unit

`default_nettype wire

// ----- dv/tb.sv -----
// tb: self-checking bench for trie_insert_lookup_engine_unit. It drives symbol beats and
// default-value writes, and keeps its own trie walk to predict every word's response.
// Depends on trie_pkg (sv/trie_pkg.sv) and the engine RTL.
`timescale 1ns / 1ps

module tb;
   import trie_pkg::*;

   localparam int ALPHABET     = 16;
   localparam int NODE_COUNT   = 1024;
   localparam int NODE_W       = $clog2(NODE_COUNT);
   localparam int DIR_ROWS     = 24;
   localparam int SETTLE       = 8;
   localparam int HOLD_CYCLES  = 400;
   localparam int LIMIT_CYCLES = 400_000;  // clear pass plus a slow, fully stalled run
   localparam int EXP_DEPTH    = 64;       // expected results in flight, a few at most

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic [SYM_W-1:0]          symbol;
      logic                      empty_word;
      logic                      last_symbol;
      logic signed [VALUE_W-1:0] store_value;
   } req_beat_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [STATUS_W-1:0]       status;
   } word_result_type;

   typedef struct packed {
      req_beat_type    beat;
      logic            typed;   // response typed in below rather than predicted
      word_result_type want;
   } dir_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic signed [VALUE_W-1:0] csr_default_value = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [CMD_W-1:0]          req_command = '0;
   logic [SYM_W-1:0]          req_symbol = '0;
   logic                      req_empty_word = 1'b0;
   logic                      req_last_symbol = 1'b0;
   logic signed [VALUE_W-1:0] req_store_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_value;
   logic [STATUS_W-1:0]       rsp_status;

   // trie state mirrored on the bench side
   logic [NODE_W-1:0]         trie_child [0:NODE_COUNT*ALPHABET-1];
   logic signed [VALUE_W-1:0] trie_value [0:NODE_COUNT-1];
   logic signed [VALUE_W-1:0] dflt_value;
   int                        free_node;
   logic [NODE_W-1:0]         walk_node;
   bit                        walk_failed;
   bit                        walk_full;

   // expected word results, oldest first
   word_result_type exp_ring [0:EXP_DEPTH-1];
   int              exp_wr_count = 0;
   int              exp_rd_count = 0;

   dir_row_type  dir_rows [0:DIR_ROWS-1];
   int           beats_sent = 0;
   int           full_words = 0;
   int           mismatch_count = 0;
   int unsigned  cycle_count = 0;
   bit           hold_long = 1'b0;
   bit           steady = 1'b0;

   trie_insert_lookup_engine_unit #(
      .ALPHABET   (ALPHABET),
      .NODE_COUNT (NODE_COUNT)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_default_value (csr_default_value),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_symbol        (req_symbol),
      .req_empty_word    (req_empty_word),
      .req_last_symbol   (req_last_symbol),
      .req_store_value   (req_store_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_value         (rsp_value),
      .rsp_status        (rsp_status)
   );

   always #10 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Walk one symbol beat through the trie; a word-ending beat yields its response.
   function automatic void advance_word(input req_beat_type b, output bit produced,
                                        output word_result_type res);
      int                slot;
      logic [NODE_W-1:0] nxt;
      produced = 1'b0;
      res = '0;
      if (!b.empty_word) begin
         if (!walk_failed) begin
            if (b.symbol >= ALPHABET) begin
               walk_failed = 1'b1;
               walk_full = 1'b0;
            end else begin
               slot = walk_node * ALPHABET + b.symbol;
               nxt = trie_child[slot];
               if (nxt == 0 && (b.command == CMD_LOOKUP || b.command == CMD_UNUSED)) begin
                  walk_failed = 1'b1;
                  walk_full = 1'b0;
               end else if (nxt == 0 && free_node >= NODE_COUNT) begin
                  walk_failed = 1'b1;
                  walk_full = 1'b1;
               end else begin
                  if (nxt == 0) begin
                     nxt = free_node[NODE_W-1:0];
                     free_node++;
                     trie_child[slot] = nxt;
                     trie_value[nxt] = dflt_value;
                  end
                  walk_node = nxt;
               end
            end
         end
         if (!b.last_symbol) return;
      end
      // word ends here: empty-word flag or last symbol
      produced = 1'b1;
      if (walk_failed) begin
         res.value = '0;
         res.status = walk_full ? STATUS_FULL : STATUS_MISS;
      end else begin
         if (b.command == CMD_INSERT) trie_value[walk_node] = b.store_value;
         res.value = trie_value[walk_node];
         res.status = STATUS_OK;
      end
      walk_node = '0;
      walk_failed = 1'b0;
      walk_full = 1'b0;
   endfunction

   function automatic dir_row_type mk_row(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym,
                                          bit empty, bit last, logic [VALUE_W-1:0] sv,
                                          bit typed, logic [VALUE_W-1:0] val,
                                          logic [STATUS_W-1:0] st);
      dir_row_type r;
      r.beat.command = cmd;
      r.beat.symbol = sym;
      r.beat.empty_word = empty;
      r.beat.last_symbol = last;
      r.beat.store_value = sv;
      r.typed = typed;
      r.want.value = val;
      r.want.status = st;
      return r;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CMD_W-1:0] pick_command();
      int r;
      r = $urandom_range(0, 19);
      if (r < 7) return CMD_INSERT;
      if (r < 14) return CMD_LOOKUP;
      if (r < 18) return CMD_TOUCH;
      return CMD_UNUSED;
   endfunction

   // Offer one request beat, hold it until accepted, then predict.
   task automatic offer_beat(input req_beat_type b, input bit typed,
                             input word_result_type want);
      bit              produced;
      word_result_type res;
      if (!steady && ((beats_sent / 64) % 4 != 3) && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= b.command;
      req_symbol      <= b.symbol;
      req_empty_word  <= b.empty_word;
      req_last_symbol <= b.last_symbol;
      req_store_value <= b.store_value;
      do @(posedge clock); while (req_ready !== 1'b1);
      beats_sent++;
      advance_word(b, produced, res);
      if (produced) begin
         if (typed) res = want;
         if (res.status == STATUS_FULL) full_words++;
         exp_ring[exp_wr_count % EXP_DEPTH] = res;
         exp_wr_count++;
      end
   endtask

   // Stop offering, wait for every pending response, then let the engine settle.
   task automatic drain(input int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (exp_rd_count != exp_wr_count);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_default(input logic [VALUE_W-1:0] v);
      csr_valid         <= 1'b1;
      csr_default_value <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      dflt_value = v;
      trie_value[0] = v;
   endtask

   // One word: symbols of one command (sometimes mixed), ended by last or by the empty flag.
   task automatic send_word(input int max_len, input bit filling);
      int               len;
      int               i;
      bit               flag_end;
      bit               narrow;
      logic [CMD_W-1:0] cmd;
      req_beat_type     b;
      cmd = filling ? ($urandom_range(0, 1) ? CMD_TOUCH : CMD_INSERT) : pick_command();
      len = filling ? $urandom_range(8, max_len) : $urandom_range(0, max_len);
      flag_end = (len == 0) || ($urandom_range(0, 6) == 0);
      narrow = !filling && $urandom_range(0, 1);
      for (i = 0; i < len; i++) begin
         b.command = (!filling && $urandom_range(0, 9) == 0) ? pick_command() : cmd;
         b.symbol = narrow ? SYM_W'($urandom_range(0, 3)) : SYM_W'($urandom_range(0, 15));
         b.empty_word = 1'b0;
         b.last_symbol = (i == len - 1) && !flag_end;
         b.store_value = pick_value();
         offer_beat(b, 1'b0, '0);
      end
      if (flag_end) begin
         b.command = cmd;
         b.symbol = SYM_W'($urandom_range(0, 15));
         b.empty_word = 1'b1;
         b.last_symbol = 1'($urandom_range(0, 1));
         b.store_value = pick_value();
         offer_beat(b, 1'b0, '0);
      end
   endtask

   // Mostly well-formed words, with some fully random noise beats.
   task automatic run_words(input int count);
      int           target;
      req_beat_type b;
      target = beats_sent + count;
      while (beats_sent < target) begin
         if ($urandom_range(0, 9) == 0) begin
            b.command = CMD_W'($urandom_range(0, 3));
            b.symbol = SYM_W'($urandom_range(0, 15));
            b.empty_word = ($urandom_range(0, 3) == 0);
            b.last_symbol = 1'($urandom_range(0, 1));
            b.store_value = $urandom;
            offer_beat(b, 1'b0, '0);
         end else begin
            send_word(6, 1'b0);
         end
      end
   endtask

   // Response side: random stalls, one long hold-off on request, none once steady.
   initial begin : rsp_side
      int n;
      forever begin
         if (hold_long) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_long = 1'b0;
         end else if (steady || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
            if (steady) n = 1;
            else n = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 30);
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
      end
   end

   // Compare each response beat with the oldest expected word result.
   always @(posedge clock) begin : rsp_check
      word_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (exp_rd_count == exp_wr_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: value %0d status %0d", rsp_value, rsp_status);
         end else begin
            want = exp_ring[exp_rd_count % EXP_DEPTH];
            exp_rd_count++;
            if (rsp_value !== want.value || rsp_status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response mismatch: expected value %0d status %0d, got %0d / %0d",
                           want.value, want.status, rsp_value, rsp_status);
            end
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= LIMIT_CYCLES);
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      // trie after reset: no children, root only
      foreach (trie_child[i]) trie_child[i] = '0;
      foreach (trie_value[i]) trie_value[i] = '0;
      dflt_value = '0;
      free_node = 1;
      walk_node = '0;
      walk_failed = 1'b0;
      walk_full = 1'b0;

      // directed words, default value at its minimum
      dir_rows = '{
         mk_row(CMD_LOOKUP,  0, 1, 0, 0,       1, VAL_MIN, STATUS_OK),   // root, no symbols
         mk_row(CMD_INSERT,  0, 1, 1, VAL_MAX, 1, VAL_MAX, STATUS_OK),
         mk_row(CMD_LOOKUP,  0, 1, 0, 0,       1, VAL_MAX, STATUS_OK),
         mk_row(CMD_LOOKUP,  5, 0, 1, 0,       1, 0,       STATUS_MISS),
         mk_row(CMD_LOOKUP, 15, 0, 0, 0,       0, 0,       STATUS_OK),   // miss, rest skipped
         mk_row(CMD_LOOKUP,  0, 0, 1, 0,       1, 0,       STATUS_MISS),
         mk_row(CMD_INSERT,  0, 0, 0, 123,     0, 0,       STATUS_OK),
         mk_row(CMD_INSERT, 15, 0, 1, '1,      1, '1,      STATUS_OK),
         mk_row(CMD_TOUCH,   0, 0, 0, 0,       0, 0,       STATUS_OK),
         mk_row(CMD_TOUCH,  15, 0, 1, 5,       1, '1,      STATUS_OK),
         mk_row(CMD_TOUCH,   0, 0, 0, 0,       0, 0,       STATUS_OK),
         mk_row(CMD_TOUCH,  14, 0, 1, 0,       1, VAL_MIN, STATUS_OK),   // fresh node
         mk_row(CMD_LOOKUP,  0, 0, 0, 0,       0, 0,       STATUS_OK),
         mk_row(CMD_LOOKUP,  9, 1, 1, 0,       1, VAL_MIN, STATUS_OK),   // empty flag mid-word
         mk_row(CMD_UNUSED,  0, 0, 0, 0,       0, 0,       STATUS_OK),
         mk_row(CMD_UNUSED, 15, 0, 1, 0,       1, '1,      STATUS_OK),
         mk_row(CMD_UNUSED,  7, 0, 1, 0,       1, 0,       STATUS_MISS),
         mk_row(CMD_LOOKUP,  0, 0, 0, 0,       0, 0,       STATUS_OK),   // mixed commands
         mk_row(CMD_INSERT,  3, 0, 1, VAL_MIN, 1, VAL_MIN, STATUS_OK),
         mk_row(CMD_INSERT,  1, 0, 1, 0,       1, 0,       STATUS_OK),
         mk_row(CMD_TOUCH,   0, 1, 0, 0,       1, VAL_MAX, STATUS_OK),
         mk_row(CMD_INSERT,  1, 0, 0, 0,       0, 0,       STATUS_OK),
         mk_row(CMD_INSERT,  2, 1, 0, 42,      0, 0,       STATUS_OK),
         mk_row(CMD_LOOKUP,  1, 0, 1, 0,       0, 0,       STATUS_OK)
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_default(VAL_MIN);   // taken during the clearing pass
      foreach (dir_rows[i]) offer_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
      drain(SETTLE);

      // short words; long response hold-off first, then a full drain midway
      write_default($urandom);
      hold_long = 1'b1;
      run_words(100);
      drain(0);
      run_words(70);
      drain(SETTLE);

      // long allocating words until the node pool runs out
      write_default(VAL_MAX);
      while (free_node < NODE_COUNT || full_words < 3) send_word(24, 1'b1);
      drain(SETTLE);

      // pool full: known paths still hit, new ones report full
      write_default('0);
      run_words(60);
      drain(SETTLE);
      write_default('1);
      steady = 1'b1;
      run_words(60);
      drain(SETTLE);

      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
